### design/lgge_pkg.sv
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and constants for the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

	localparam int ADDR_W = 7;

	// Rule B3/S23: birth on three neighbors, survival on two or three.
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT  = 4'd2;

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_ADVANCE = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef struct packed {
		func_t             func;
		logic [ADDR_W-1:0] row;
		logic [ADDR_W-1:0] col;
		logic              value;
	} cmd_t;

	typedef struct packed {
		logic       cell_state;
		logic [1:0] done_kind;
	} rsp_t;

endpackage

### design/life_grid_generation_engine_core.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine_core
// Game of Life (B3/S23) grid engine: cell write, cell read, clear and
// one-generation advance over a GRID_ROWS x GRID_COLS grid.
// ----------------------------------------------------------------------------
// The grid lives in a row-wide memory with one read and one write port. A
// cell write or read goes from accept through a row read, a bit update and
// the result. A clear sweeps one row per cycle. An advance runs one shared
// cell evaluation unit over the grid one cell per cycle, holding three rows
// of the old generation in line buffers and writing each new row back after
// its scan. After reset the grid memory is cleared by a sweep during which
// cmd_ready stays low. One command is worked on at a time; the next is taken
// while a result still waits on rsp.
// Cells outside the grid count as dead; out-of-grid writes are dropped and
// out-of-grid reads return 0.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_core
	import lgge_pkg::*;
#(
	parameter int GRID_ROWS = 128,
	parameter int GRID_COLS = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int RW = $clog2(GRID_ROWS);
	localparam int CW = $clog2(GRID_COLS);
	localparam int KW = $clog2(GRID_COLS + 1);

	typedef enum logic [8:0] {
		S_INIT = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_ROW  = 9'b000000100,
		S_CLR  = 9'b000001000,
		S_AP0  = 9'b000010000,
		S_AP1  = 9'b000100000,
		S_SCAN = 9'b001000000,
		S_WB   = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic                 inside_q;
	logic                 cell_q;
	logic [RW-1:0]        rcnt_q;
	logic [KW-1:0]        kcnt_q;
	logic [GRID_COLS-1:0] prev_q;
	logic [GRID_COLS-1:0] cur_q;
	logic [GRID_COLS-1:0] next_q;
	logic [GRID_COLS-1:0] res_q;
	logic [2:0]           wl_q;
	logic [2:0]           wm_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 mem_we;
	logic [RW-1:0]        mem_waddr;
	logic [GRID_COLS-1:0] mem_wdata;
	logic [RW-1:0]        mem_raddr;
	logic [GRID_COLS-1:0] mem_rdata_q;

	logic                 cmd_fire;
	logic                 cmd_inside;
	logic                 out_free;
	logic [RW:0]          nxt_full;
	logic                 nxt_ok;
	logic [RW-1:0]        row_ix_q;
	logic [CW-1:0]        col_ix_q;
	logic [CW-1:0]        kix;
	logic [2:0]           colbits;
	logic                 cell_nxt;
	logic [GRID_COLS-1:0] rmw_data;

	assign cmd_ready  = (state_q == S_IDLE);
	assign cmd_fire   = cmd_valid && cmd_ready;
	assign cmd_inside = (int'(cmd.row) < GRID_ROWS) && (int'(cmd.col) < GRID_COLS);
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign row_ix_q = RW'(cmd_q.row);
	assign col_ix_q = CW'(cmd_q.col);
	assign nxt_full = (RW + 1)'(rcnt_q) + (RW + 1)'(2);
	assign nxt_ok   = nxt_full < (RW + 1)'(GRID_ROWS);
	assign kix      = kcnt_q[CW-1:0];

	always_comb begin
		colbits = 3'b000;
		if (kcnt_q < KW'(GRID_COLS)) begin
			colbits = {prev_q[kix], cur_q[kix], next_q[kix]};
		end
	end

	lgge_cell_unit u_cell (
		.left_col  (wl_q),
		.mid_col   (wm_q),
		.right_col (colbits),
		.cell_next (cell_nxt)
	);

	always_comb begin
		rmw_data           = mem_rdata_q;
		rmw_data[col_ix_q] = cmd_q.value;
	end

	always_comb begin
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: mem_raddr = (cmd.func == FUNC_ADVANCE) ? '0 : RW'(cmd.row);
			S_AP0:  mem_raddr = RW'(1);
			S_SCAN: mem_raddr = nxt_ok ? nxt_full[RW-1:0] : '0;
			default: mem_raddr = '0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rcnt_q;
		mem_wdata = '0;
		unique case (state_q)
			S_INIT, S_CLR: begin
				mem_we = 1'b1;
			end
			S_ROW: begin
				mem_we    = (cmd_q.func == FUNC_WRITE) && inside_q;
				mem_waddr = row_ix_q;
				mem_wdata = rmw_data;
			end
			S_WB: begin
				mem_we    = 1'b1;
				mem_wdata = res_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	lgge_grid_mem #(
		.DEPTH (GRID_ROWS),
		.WIDTH (GRID_COLS)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rcnt_q      <= '0;
			kcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (rcnt_q == RW'(GRID_ROWS - 1)) begin
						rcnt_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						rcnt_q <= rcnt_q + RW'(1);
					end
				end
				S_IDLE: begin
					if (cmd_fire) begin
						rcnt_q <= '0;
						unique case (cmd.func)
							FUNC_WRITE, FUNC_READ: state_q <= S_ROW;
							FUNC_ADVANCE:          state_q <= S_AP0;
							FUNC_CLEAR:            state_q <= S_CLR;
							default:               state_q <= S_ROW;
						endcase
					end
				end
				S_ROW: begin
					state_q <= S_DONE;
				end
				S_CLR: begin
					if (rcnt_q == RW'(GRID_ROWS - 1)) begin
						rcnt_q  <= '0;
						state_q <= S_DONE;
					end else begin
						rcnt_q <= rcnt_q + RW'(1);
					end
				end
				S_AP0: begin
					state_q <= S_AP1;
				end
				S_AP1: begin
					kcnt_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					kcnt_q <= kcnt_q + KW'(1);
					if (kcnt_q == KW'(GRID_COLS)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					kcnt_q <= '0;
					if (rcnt_q == RW'(GRID_ROWS - 1)) begin
						rcnt_q  <= '0;
						state_q <= S_DONE;
					end else begin
						rcnt_q  <= rcnt_q + RW'(1);
						state_q <= S_SCAN;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_q    <= cmd;
			inside_q <= cmd_inside;
			cell_q   <= 1'b0;
		end
		if (state_q == S_ROW) begin
			cell_q <= (cmd_q.func == FUNC_READ) && inside_q && mem_rdata_q[col_ix_q];
		end
		if (state_q == S_AP0) begin
			prev_q <= '0;
			cur_q  <= mem_rdata_q;
		end
		if (state_q == S_AP1) begin
			next_q <= mem_rdata_q;
			wl_q   <= 3'b000;
			wm_q   <= 3'b000;
		end
		if (state_q == S_SCAN) begin
			if (kcnt_q != '0) begin
				res_q <= {cell_nxt, res_q[GRID_COLS-1:1]};
			end
			wl_q <= wm_q;
			wm_q <= colbits;
		end
		if (state_q == S_WB) begin
			prev_q <= cur_q;
			cur_q  <= next_q;
			next_q <= nxt_ok ? mem_rdata_q : '0;
			wl_q   <= 3'b000;
			wm_q   <= 3'b000;
		end
		if ((state_q == S_DONE) && out_free) begin
			rsp_q.cell_state <= cell_q;
			rsp_q.done_kind  <= cmd_q.func;
		end
	end

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("grid written while idle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (kcnt_q <= KW'(GRID_COLS)))
		else $error("column count past grid width");

	a_adv_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && (cmd.func == FUNC_ADVANCE)) |=> (state_q == S_AP0))
		else $error("advance did not start with row load");

	a_last_row_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WB) && (rcnt_q == RW'(GRID_ROWS - 1))) |=> (state_q == S_DONE))
		else $error("advance did not finish after last row");

	a_cell_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.cell_state) |-> (rsp_q.done_kind == FUNC_READ))
		else $error("cell state set on non-read beat");

endmodule

### design/lgge_cell_unit.sv
// ----------------------------------------------------------------------------
// lgge_cell_unit
// Next-state evaluation of one cell from its 3x3 neighborhood window.
// Each column is {upper, center, lower}.
// ----------------------------------------------------------------------------
module lgge_cell_unit
	import lgge_pkg::*;
(
	input  logic [2:0] left_col,
	input  logic [2:0] mid_col,
	input  logic [2:0] right_col,
	output logic       cell_next
);

	logic [3:0] count;

	always_comb begin
		count = 4'd0;
		for (int i = 0; i < 3; i++) begin
			count = count + 4'(left_col[i]) + 4'(right_col[i]);
		end
		count = count + 4'(mid_col[2]) + 4'(mid_col[0]);
		cell_next = (count == BIRTH_COUNT) || ((count == KEEP_COUNT) && mid_col[1]);
	end

endmodule

### design/lgge_grid_mem.sv
// ----------------------------------------------------------------------------
// lgge_grid_mem
// Row-organized grid store: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module lgge_grid_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

### bench/life_grid_generation_engine_core_test.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine_core_test
// Self-checking bench for the Game of Life grid engine. A queue of commands
// drives the cmd channel: directed corner and edge cases first, then random
// pattern windows that are written, stepped and read back, mixed with
// commands at random addresses. Every accepted command is run through a bench
// copy of the grid, and each rsp beat is compared field by field, in order.
// The cmd side sends in bursts with gaps, and the rsp side stalls on its own
// pattern, with long hold-offs that back the engine up.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_core_test;
	import lgge_pkg::*;

	localparam int GRID_ROWS = 128;
	localparam int GRID_COLS = 128;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	cmd_t pending_cmds[$];
	rsp_t awaited_rsps[$];
	bit [GRID_COLS-1:0] life_cells [GRID_ROWS];

	logic cmd_taken = 1'b0;
	rsp_t want;
	int total_cmds = 0;
	int cmds_accepted = 0;
	int rsps_checked = 0;
	int mismatches = 0;
	int n_writes = 0;
	int n_reads = 0;
	int n_live_reads = 0;
	int n_steps = 0;
	int n_clears = 0;

	int burst_left = 0;
	int idle_gap = 0;
	int hold_left = 0;
	int long_holds = 0;
	int mode_left = 0;
	int ready_mode = 0;

	life_grid_generation_engine_core #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void step_generation();
		bit [GRID_COLS-1:0] prior [GRID_ROWS];
		int n;
		prior = life_cells;
		for (int r = 0; r < GRID_ROWS; r++) begin
			for (int c = 0; c < GRID_COLS; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_ROWS &&
							c + dc >= 0 && c + dc < GRID_COLS) begin
							n += prior[r + dr][c + dc];
						end
					end
				end
				if (n == BIRTH_COUNT) begin
					life_cells[r][c] = 1'b1;
				end else if (n < KEEP_COUNT || n > BIRTH_COUNT) begin
					life_cells[r][c] = 1'b0;
				end
			end
		end
	endfunction

	function automatic rsp_t apply_command(cmd_t c);
		rsp_t r;
		r.cell_state = 1'b0;
		r.done_kind = c.func;
		case (c.func)
			FUNC_WRITE: begin
				n_writes++;
				if (c.row < GRID_ROWS && c.col < GRID_COLS) begin
					life_cells[c.row][c.col] = c.value;
				end
			end
			FUNC_READ: begin
				n_reads++;
				if (c.row < GRID_ROWS && c.col < GRID_COLS) begin
					r.cell_state = life_cells[c.row][c.col];
				end
				if (r.cell_state) begin
					n_live_reads++;
				end
			end
			FUNC_ADVANCE: begin
				n_steps++;
				step_generation();
			end
			default: begin
				n_clears++;
				foreach (life_cells[i]) begin
					life_cells[i] = '0;
				end
			end
		endcase
		return r;
	endfunction

	task automatic queue_cmd(func_t f, int r, int c, int v);
		cmd_t item;
		item.func = f;
		item.row = r[ADDR_W-1:0];
		item.col = c[ADDR_W-1:0];
		item.value = v[0];
		pending_cmds.push_back(item);
		total_cmds++;
	endtask

	// Bias pattern windows toward the grid edges.
	function automatic int pick_origin();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return GRID_ROWS - 4;
			default: return $urandom_range(0, GRID_ROWS - 4);
		endcase
	endfunction

	function automatic int clamp_index(int v);
		if (v < 0) begin
			return 0;
		end
		if (v > GRID_ROWS - 1) begin
			return GRID_ROWS - 1;
		end
		return v;
	endfunction

	// Monitor and scoreboard.
	always @(posedge clk) begin
		cmd_taken <= cmd_valid && cmd_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsps_checked++;
				if (awaited_rsps.size() == 0) begin
					$display("%0t: unexpected rsp beat: cell_state %0b done_kind %0d",
						$time, rsp.cell_state, rsp.done_kind);
					mismatches++;
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.cell_state !== want.cell_state) begin
						$display("%0t: cell_state expected %0b, got %0b",
							$time, want.cell_state, rsp.cell_state);
						mismatches++;
					end
					if (rsp.done_kind !== want.done_kind) begin
						$display("%0t: done_kind expected %0d, got %0d",
							$time, want.done_kind, rsp.done_kind);
						mismatches++;
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				awaited_rsps.push_back(apply_command(cmd));
				cmds_accepted++;
			end
		end
	end

	// Command driver: bursts with random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd_valid || cmd_taken) begin
				if (idle_gap > 0 || pending_cmds.size() == 0) begin
					cmd_valid <= 1'b0;
					if (idle_gap > 0) begin
						idle_gap--;
					end
				end else begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// Response side: switch between stall modes; hold off long twice.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else if ((long_holds == 0 && rsps_checked >= 4) ||
				(long_holds == 1 && rsps_checked >= 60)) begin
				long_holds++;
				hold_left = 300;
				rsp_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(4, 40);
					ready_mode = $urandom_range(0, 2);
				end
				mode_left--;
				case (ready_mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= ($urandom_range(0, 3) != 0);
					default: rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int r0;
		int c0;
		int kind;
		int steps_planned;
		steps_planned = 0;

		// Corners, a blinker cut by the top edge, overwrite, clear, empty step.
		queue_cmd(FUNC_READ, 0, 0, 0);
		queue_cmd(FUNC_WRITE, 0, 0, 1);
		queue_cmd(FUNC_READ, 0, 0, 1);
		queue_cmd(FUNC_WRITE, 127, 127, 1);
		queue_cmd(FUNC_WRITE, 0, 127, 1);
		queue_cmd(FUNC_WRITE, 127, 0, 1);
		queue_cmd(FUNC_READ, 127, 127, 0);
		queue_cmd(FUNC_WRITE, 0, 5, 1);
		queue_cmd(FUNC_WRITE, 0, 6, 1);
		queue_cmd(FUNC_WRITE, 0, 7, 1);
		queue_cmd(FUNC_ADVANCE, 127, 127, 1);
		queue_cmd(FUNC_READ, 0, 6, 0);
		queue_cmd(FUNC_READ, 1, 6, 0);
		queue_cmd(FUNC_READ, 0, 5, 0);
		queue_cmd(FUNC_READ, 127, 127, 0);
		queue_cmd(FUNC_READ, 0, 0, 0);
		queue_cmd(FUNC_WRITE, 0, 6, 0);
		queue_cmd(FUNC_READ, 0, 6, 1);
		queue_cmd(FUNC_CLEAR, 127, 127, 1);
		queue_cmd(FUNC_READ, 1, 6, 0);
		queue_cmd(FUNC_ADVANCE, 0, 0, 0);
		queue_cmd(FUNC_READ, 64, 64, 0);

		while (total_cmds < 90) begin
			if ($urandom_range(0, 3) == 0) begin
				queue_cmd(FUNC_CLEAR, $urandom, $urandom, $urandom);
			end
			r0 = pick_origin();
			c0 = pick_origin();
			repeat ($urandom_range(4, 10)) begin
				queue_cmd(FUNC_WRITE, r0 + $urandom_range(0, 3), c0 + $urandom_range(0, 3),
					$urandom_range(0, 4) != 0);
			end
			repeat ($urandom_range(1, 2)) begin
				if (steps_planned < 16) begin
					queue_cmd(FUNC_ADVANCE, $urandom, $urandom, $urandom);
					steps_planned++;
				end
			end
			repeat ($urandom_range(6, 10)) begin
				queue_cmd(FUNC_READ, clamp_index(r0 - 1 + $urandom_range(0, 5)),
					clamp_index(c0 - 1 + $urandom_range(0, 5)), $urandom);
			end
			repeat ($urandom_range(1, 3)) begin
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					queue_cmd(FUNC_WRITE, $urandom, $urandom, $urandom);
				end else if (kind < 8) begin
					queue_cmd(FUNC_READ, $urandom, $urandom, $urandom);
				end else if (kind == 8) begin
					queue_cmd(FUNC_CLEAR, $urandom, $urandom, $urandom);
				end else if (steps_planned < 16) begin
					queue_cmd(FUNC_ADVANCE, $urandom, $urandom, $urandom);
					steps_planned++;
				end
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmds_accepted < total_cmds || awaited_rsps.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);

		$display("Ran %0d commands: %0d writes, %0d reads (%0d live), %0d generation steps,",
			cmds_accepted, n_writes, n_reads, n_live_reads, n_steps);
		$display("%0d clears; %0d rsp beats checked, %0d mismatches.",
			n_clears, rsps_checked, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Timed out with %0d of %0d commands accepted.", cmds_accepted, total_cmds);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### life_grid_generation_engine_core.f
design/lgge_pkg.sv
design/lgge_cell_unit.sv
design/lgge_grid_mem.sv
design/life_grid_generation_engine_core.sv
bench/life_grid_generation_engine_core_test.sv
